// ===== src/hav_pkg.sv =====
// hav_pkg: constants, tables and types shared by the haversine distance pipeline
// no dependencies; used by hav_sincos, hav_isqrt, haversine_distance and hav_checker
package hav_pkg;

  // fixed-point formats
  localparam int ANGLE_FRAC_BITS = 22;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int CORDIC_STEPS    = 30;

  // degrees to binary angle: 2^(32-F)/360 = K/45 with K = 2^(29-F)
  localparam int ANG_K_SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int ANG_K       = 1 << ANG_K_SHIFT;
  localparam int TAB_W       = ANG_K_SHIFT + 1;
  localparam int TAB_LEN     = 45;

  // floor(m / 45) by reciprocal, one correction step afterwards
  localparam int RECIP_SHIFT = 37;
  localparam logic [31:0] RECIP_45 = 32'd3054198966;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [32:0] GAIN_INV_Q30 = 33'sd652032874;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  localparam int DIST_W     = 33;
  localparam int DIST_SHIFT = 29 - DIST_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // latencies of the pipeline sections
  localparam int TURN_LAT   = 5;
  localparam int SINCOS_LAT = CORDIC_STEPS + 3;
  localparam int PROD_LAT   = 5;
  localparam int SQRT_BITS  = 31;
  localparam int SQRT_LAT   = SQRT_BITS;
  localparam int FINAL_LAT  = 2;
  localparam int PIPE_LAT   = TURN_LAT + SINCOS_LAT + PROD_LAT + SQRT_LAT
                              + CORDIC_STEPS + FINAL_LAT;

  localparam int ATAN_Q30 [CORDIC_STEPS] = '{
    843314856, 497837829, 263043837, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2
  };

  typedef logic [TAB_W-1:0] turn_tab_t [TAB_LEN];

  // residue correction for a full angle: floor((2*K*b + 45) / 90)
  function automatic turn_tab_t make_tab_abs();
    turn_tab_t t;
    for (int b = 0; b < TAB_LEN; b++) begin
      t[b] = TAB_W'((2 * ANG_K * b + 45) / 90);
    end
    return t;
  endfunction

  // residue correction for a half difference: floor((K*b + 45) / 90)
  function automatic turn_tab_t make_tab_dif();
    turn_tab_t t;
    for (int b = 0; b < TAB_LEN; b++) begin
      t[b] = TAB_W'((ANG_K * b + 45) / 90);
    end
    return t;
  endfunction

  localparam turn_tab_t TAB_ABS = make_tab_abs();
  localparam turn_tab_t TAB_DIF = make_tab_dif();

endpackage

// ===== src/hav_sincos.sv =====
// hav_sincos: pipelined rotation cordic, binary angle in, sine and cosine Q30 out
// depends on hav_pkg
module hav_sincos
  import hav_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         angle,
  output logic signed [32:0]  sin_q,
  output logic signed [32:0]  cos_q
);

  logic [1:0]         quad;
  logic [31:0]        res;
  logic [1:0]         pre_quad;
  logic signed [63:0] pre_prod;
  logic signed [63:0] pre_round;

  logic signed [32:0] cx [CORDIC_STEPS+1];
  logic signed [32:0] cy [CORDIC_STEPS+1];
  logic signed [32:0] cz [CORDIC_STEPS+1];
  logic [1:0]         qd [CORDIC_STEPS+1];

  // quadrant split and residue to radians
  assign quad = 2'((angle + 32'h2000_0000) >> 30);
  assign res  = angle - {quad, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      pre_quad <= quad;
      pre_prod <= $signed(res) * $signed({1'b0, HALF_PI_Q30});
    end
  end

  assign pre_round = (pre_prod + 64'sd536870912) >>> 30;

  // cordic start vector
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= GAIN_INV_Q30;
      cy[0] <= '0;
      cz[0] <= 33'(pre_round);
      qd[0] <= pre_quad;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][32]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - 33'(ATAN_Q30[i]);
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + 33'(ATAN_Q30[i]);
        end
        qd[i+1] <= qd[i];
      end
    end
  end

  // quadrant unfold
  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[CORDIC_STEPS])
        2'd0: begin
          cos_q <= cx[CORDIC_STEPS];
          sin_q <= cy[CORDIC_STEPS];
        end
        2'd1: begin
          cos_q <= -cy[CORDIC_STEPS];
          sin_q <= cx[CORDIC_STEPS];
        end
        2'd2: begin
          cos_q <= -cx[CORDIC_STEPS];
          sin_q <= -cy[CORDIC_STEPS];
        end
        default: begin
          cos_q <= cy[CORDIC_STEPS];
          sin_q <= -cx[CORDIC_STEPS];
        end
      endcase
    end
  end

endmodule

// ===== src/hav_isqrt.sv =====
// hav_isqrt: pipelined floor square root, one result bit per stage
// depends on hav_pkg
module hav_isqrt
  import hav_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*SQRT_BITS-2:0] value,
  output logic [SQRT_BITS-1:0]  root
);

  localparam int REM_W = 2 * SQRT_BITS;

  logic [REM_W-1:0]     rem [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] rt  [SQRT_BITS+1];

  assign rem[0] = REM_W'(value);
  assign rt[0]  = '0;

  // stage k decides root bit SQRT_BITS-1-k
  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_bit
    localparam int B = SQRT_BITS - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = (REM_W'(rt[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          rt[k+1]  <= rt[k] | (SQRT_BITS'(1) << B);
        end else begin
          rem[k+1] <= rem[k];
          rt[k+1]  <= rt[k];
        end
      end
    end
  end

  assign root = rt[SQRT_BITS];

endmodule

// ===== src/haversine_distance.sv =====
// haversine_distance: great circle distance of two points, fully pipelined
// depends on hav_pkg, hav_sincos, hav_isqrt
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------------------
//  pair     | pair_valid  | pair_stall  | first_lat first_lon second_lat second_lon
//  dist     | dist_valid  | dist_stall  | distance
//  config   | cfg_wr_en   | none        | cfg_wr_data (sphere radius)
//
// one pair per cycle while no result is held; most of the depth comes from
// the two 30-step cordics and the 31-stage square root.
// a stalled result freezes the whole pipeline, so the pair side stalls
// exactly while a result is held; bubbles travel with cleared valid bits.
// synchronous reset clears the valid bits and loads the default radius.
module haversine_distance
  import hav_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [22:0]           cfg_wr_data,
  input  logic                  pair_valid,
  output logic                  pair_stall,
  input  logic signed [29:0]    first_lat,
  input  logic signed [30:0]    first_lon,
  input  logic signed [29:0]    second_lat,
  input  logic signed [30:0]    second_lon,
  output logic                  dist_valid,
  input  logic                  dist_stall,
  output logic [DIST_W-1:0]     distance
);

  localparam int LANES = 4;

  logic                en;
  logic [22:0]         radius;
  logic [PIPE_LAT-1:0] vld;

  // pipeline advances unless a result is held
  assign en         = !(vld[PIPE_LAT-1] && dist_stall);
  assign pair_stall = !en;
  assign dist_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], pair_valid};
    end
  end

  // lanes: first lat, second lat, lat difference, lon difference
  logic signed [31:0] raw [LANES];
  assign raw[0] = 32'(first_lat);
  assign raw[1] = 32'(second_lat);
  assign raw[2] = 32'(second_lat) - 32'(first_lat);
  assign raw[3] = 32'(second_lon) - 32'(first_lon);

  logic signed [32:0] sn [LANES];
  logic signed [32:0] cs [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    localparam bit IS_DIF = (g >= 2);

    logic [31:0]        s1_mag;
    logic               s1_neg;
    logic [31:0]        s2_mag;
    logic [63:0]        s2_prod;
    logic               s2_neg;
    logic [26:0]        q0;
    logic [31:0]        rem_full;
    logic [26:0]        s3_q;
    logic [6:0]         s3_rem;
    logic               s3_neg;
    logic [26:0]        s4_q;
    logic [5:0]         s4_b;
    logic               s4_neg;
    logic [31:0]        mag_turn;
    logic [31:0]        s5_turn;

    // sign and magnitude
    always_ff @(posedge clk) begin
      if (en) begin
        s1_neg <= raw[g][31];
        s1_mag <= raw[g][31] ? 32'(-raw[g]) : 32'(raw[g]);
      end
    end

    // divide by 45 through the reciprocal
    always_ff @(posedge clk) begin
      if (en) begin
        s2_prod <= 64'(s1_mag) * 64'(RECIP_45);
        s2_mag  <= s1_mag;
        s2_neg  <= s1_neg;
      end
    end

    assign q0       = s2_prod[RECIP_SHIFT +: 27];
    assign rem_full = s2_mag - 32'(q0) * 32'd45;

    always_ff @(posedge clk) begin
      if (en) begin
        s3_q   <= q0;
        s3_rem <= rem_full[6:0];
        s3_neg <= s2_neg;
      end
    end

    // quotient may be one short
    always_ff @(posedge clk) begin
      if (en) begin
        if (s3_rem >= 7'd45) begin
          s4_q <= s3_q + 27'd1;
          s4_b <= 6'(s3_rem - 7'd45);
        end else begin
          s4_q <= s3_q;
          s4_b <= s3_rem[5:0];
        end
        s4_neg <= s3_neg;
      end
    end

    // binary angle (halved for the difference lanes), modulo one turn
    if (IS_DIF) begin : g_dif
      assign mag_turn = (32'(s4_q) << (ANG_K_SHIFT - 1)) + 32'(TAB_DIF[s4_b]);
    end else begin : g_abs
      assign mag_turn = (32'(s4_q) << ANG_K_SHIFT) + 32'(TAB_ABS[s4_b]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s5_turn <= s4_neg ? -mag_turn : mag_turn;
      end
    end

    hav_sincos u_sincos (
      .clk   (clk),
      .en    (en),
      .angle (s5_turn),
      .sin_q (sn[g]),
      .cos_q (cs[g])
    );
  end

  // products of the haversine term
  logic signed [65:0] p1_lat;
  logic signed [65:0] p1_cos;
  logic signed [65:0] p1_lon;
  logic signed [32:0] p2_lat;
  logic signed [32:0] p2_cos;
  logic signed [32:0] p2_lon;
  logic signed [65:0] p3_lon;
  logic signed [32:0] p3_lat;
  logic signed [32:0] p4_lon;
  logic signed [32:0] p4_lat;
  logic signed [33:0] hsum;
  logic [30:0]        h;

  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_lat <= 66'(sn[2]) * 66'(sn[2]);
      p1_cos <= 66'(cs[0]) * 66'(cs[1]);
      p1_lon <= 66'(sn[3]) * 66'(sn[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_lat <= 33'((p1_lat + HALF_Q30) >>> 30);
      p2_cos <= 33'((p1_cos + HALF_Q30) >>> 30);
      p2_lon <= 33'((p1_lon + HALF_Q30) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_lon <= 66'(p2_cos) * 66'(p2_lon);
      p3_lat <= p2_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_lon <= 33'((p3_lon + HALF_Q30) >>> 30);
      p4_lat <= p3_lat;
    end
  end

  // sum and clamp to [0, 1]
  assign hsum = 34'(p4_lat) + 34'(p4_lon);

  always_ff @(posedge clk) begin
    if (en) begin
      if (hsum[33]) begin
        h <= '0;
      end else if (hsum > 34'sd1073741824) begin
        h <= 31'd1073741824;
      end else begin
        h <= 31'(hsum);
      end
    end
  end

  // square roots of h and 1 - h
  logic [SQRT_BITS-1:0] root_h;
  logic [SQRT_BITS-1:0] root_c;
  logic [30:0]          h_c;

  assign h_c = 31'd1073741824 - h;

  hav_isqrt u_sqrt_h (
    .clk   (clk),
    .en    (en),
    .value ({h, 30'b0}),
    .root  (root_h)
  );

  hav_isqrt u_sqrt_c (
    .clk   (clk),
    .en    (en),
    .value ({h_c, 30'b0}),
    .root  (root_c)
  );

  // vectoring cordic for the half central angle
  logic signed [32:0] vx [CORDIC_STEPS+1];
  logic signed [32:0] vy [CORDIC_STEPS+1];
  logic signed [32:0] vz [CORDIC_STEPS+1];

  assign vx[0] = 33'(root_c);
  assign vy[0] = 33'(root_h);
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    assign dx = vy[i] >>> i;
    assign dy = vx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy[i][32]) begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + 33'(ATAN_Q30[i]);
        end else begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - 33'(ATAN_Q30[i]);
        end
      end
    end
  end

  // angle times radius, then round and saturate
  logic [30:0] zc;
  logic [53:0] f1_prod;
  logic [54:0] f2_sum;
  logic [54:0] f2_shift;

  assign zc = vz[CORDIC_STEPS][32] ? '0 : vz[CORDIC_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod <= 54'(zc) * 54'(radius);
    end
  end

  assign f2_sum   = 55'(f1_prod) + (55'(1) << (DIST_SHIFT - 1));
  assign f2_shift = f2_sum >> DIST_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (|f2_shift[54:DIST_W]) begin
        distance <= DIST_MAX;
      end else begin
        distance <= f2_shift[DIST_W-1:0];
      end
    end
  end

endmodule

// ===== src/hav_checker.sv =====
// hav_checker: port-level checks of haversine_distance, attached by bind
// depends on hav_pkg
module hav_checker
  import hav_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wr_en,
  input logic [22:0]           cfg_wr_data,
  input logic                  pair_valid,
  input logic                  pair_stall,
  input logic signed [29:0]    first_lat,
  input logic signed [30:0]    first_lon,
  input logic signed [29:0]    second_lat,
  input logic signed [30:0]    second_lon,
  input logic                  dist_valid,
  input logic                  dist_stall,
  input logic [DIST_W-1:0]     distance
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_stall |=> dist_valid && $stable(distance))
    else $error("held distance changed");

  // request side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk)
    pair_stall |-> dist_valid && dist_stall)
    else $error("request stalled without a held result");

  // a held result stalls the request side
  a_stall_back: assert property (@(posedge clk)
    dist_valid && dist_stall |-> pair_stall)
    else $error("request taken while result held");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !dist_valid)
    else $error("result shown right after reset");

endmodule

bind haversine_distance hav_checker u_hav_checker (.*);
